// ===== hw/rtl/prob_triple_quantize_pack_core_assert.svh =====
// Assertion macros for the quantize/pack top level.
`ifndef PROB_TRIPLE_QUANTIZE_PACK_CORE_ASSERT_SVH
`define PROB_TRIPLE_QUANTIZE_PACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// implication or sequence property, checked outside reset
`define PTQP_ASSERT(label, clk_s, rstn_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("ptqp property violated");
// condition that must never be seen outside reset
`define PTQP_NEVER(label, clk_s, rstn_s, cond) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("ptqp forbidden condition seen");
`else
`define PTQP_ASSERT(label, clk_s, rstn_s, prop)
`define PTQP_NEVER(label, clk_s, rstn_s, cond)
`endif
`endif

// ===== hw/rtl/ptqp_pkg.sv =====
// Shared types and constants for the probability quantize/pack block.
`default_nettype none
package ptqp_pkg;
	localparam int PROB_W  = 33;  // probability input width
	localparam int BITS_W  = 6;   // width of bits_per_prob
	localparam int VAL_W   = 32;  // quantized value width (B max)
	localparam int NB_W    = 3;   // bytes per value, 1..4
	localparam int BYTE_W  = 8;
	localparam logic [BITS_W-1:0] B_MIN   = 6'd8;
	localparam logic [BITS_W-1:0] B_MAX   = 6'd32;
	localparam logic [BITS_W-1:0] B_RESET = 6'd16;

	// one quantized sample waiting for serialization
	typedef struct packed {
		logic [VAL_W-1:0] q0;
		logic [VAL_W-1:0] q1;
		logic [NB_W-1:0]  nbytes;
	} item_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ptqp_front.sv =====
// Front end: clamp, scale, split and largest-remainder rounding.
`default_nettype none
module ptqp_front import ptqp_pkg::*; #(
	parameter int FRAC_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [PROB_W-1:0] prob_hom_ref,
	input  wire logic [PROB_W-1:0] prob_het,
	input  wire logic [PROB_W-1:0] prob_hom_alt,
	input  wire logic              sample_missing,
	input  wire logic [BITS_W-1:0] bits_eff,
	output logic                   wr_valid,
	output item_t                  wr_item,
	output logic [1:0]             inflight
);
	localparam int CW   = (FRAC_BITS + 1 > PROB_W) ? FRAC_BITS + 1 : PROB_W;
	localparam int PRW  = CW + VAL_W;
	localparam int SUMW = FRAC_BITS + 2;
	localparam logic [CW-1:0]   ONE_C  = CW'(1) << FRAC_BITS;
	localparam logic [SUMW-1:0] HALF_C = SUMW'(1) << (FRAC_BITS - 1);

	logic [PROB_W-1:0]    prob_in [3];
	logic [PRW-1:0]       prod [3];
	logic [CW-1:0]        pc;
	logic [PRW-1:0]       ext;

	logic                 v_s1, miss_s1;
	logic [VAL_W-1:0]     ip_s1 [3];
	logic [FRAC_BITS-1:0] rm_s1 [3];
	logic [BITS_W-1:0]    b_s1;

	logic [SUMW-1:0]      rsum;
	logic [1:0]           kk;
	logic [1:0]           rank [2];
	logic [1:0]           up;

	logic                 v_s2;
	logic [VAL_W-1:0]     ip0_s2, ip1_s2;
	logic [1:0]           up_s2;
	logic [BITS_W-1:0]    b_s2;

	logic [VAL_W:0]       scale_w, qw0, qw1;

	assign prob_in[0] = prob_hom_ref;
	assign prob_in[1] = prob_het;
	assign prob_in[2] = prob_hom_alt;

	// p * (2^B - 1) as (p << B) - p
	always_comb begin
		pc  = '0;
		ext = '0;
		for (int i = 0; i < 3; i++) begin
			pc      = (CW'(prob_in[i]) > ONE_C) ? ONE_C : CW'(prob_in[i]);
			ext     = PRW'(pc);
			prod[i] = (ext << bits_eff) - ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				ip_s1[i] <= prod[i][FRAC_BITS +: VAL_W];
				rm_s1[i] <= prod[i][FRAC_BITS-1:0];
			end
			miss_s1 <= sample_missing;
			b_s1    <= bits_eff;
		end
	end

	// rounded remainder count and rank; ties rank lower index as smaller
	always_comb begin
		rsum = SUMW'(rm_s1[0]) + SUMW'(rm_s1[1]) + SUMW'(rm_s1[2]) + HALF_C;
		kk   = rsum[FRAC_BITS +: 2];
		for (int i = 0; i < 2; i++) begin
			rank[i] = 2'd0;
			for (int j = 0; j < 3; j++) begin
				if (j != i && (rm_s1[j] < rm_s1[i] || (rm_s1[j] == rm_s1[i] && j < i)))
					rank[i] = rank[i] + 2'd1;
			end
			up[i] = (3'(rank[i]) + 3'(kk) >= 3'd3) && (rm_s1[i] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			ip0_s2 <= miss_s1 ? '0 : ip_s1[0];
			ip1_s2 <= miss_s1 ? '0 : ip_s1[1];
			up_s2  <= miss_s1 ? 2'b00 : up;
			b_s2   <= b_s1;
		end
	end

	always_comb begin
		scale_w = ((VAL_W + 1)'(1) << b_s2) - (VAL_W + 1)'(1);
		qw0     = {1'b0, ip0_s2} + (VAL_W + 1)'(up_s2[0]);
		qw1     = {1'b0, ip1_s2} + (VAL_W + 1)'(up_s2[1]);
		wr_item.q0     = (qw0 > scale_w) ? scale_w[VAL_W-1:0] : qw0[VAL_W-1:0];
		wr_item.q1     = (qw1 > scale_w) ? scale_w[VAL_W-1:0] : qw1[VAL_W-1:0];
		wr_item.nbytes = b_s2[BITS_W-1:3];
	end

	assign wr_valid = v_s2;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2};
endmodule
`default_nettype wire

// ===== hw/rtl/ptqp_queue.sv =====
// Small register queue between front end and byte serializer.
`default_nettype none
module ptqp_queue import ptqp_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire item_t                      wr_item,
	input  wire logic                       rd_en,
	output item_t                           rd_item,
	output logic                            rd_valid,
	output logic [$clog2(DEPTH + 1)-1:0]    level
);
	localparam int PTRW = $clog2(DEPTH);
	localparam int LW   = $clog2(DEPTH + 1);

	item_t           mem_q [DEPTH];
	logic [PTRW-1:0] wptr_q, rptr_q;
	logic [LW-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en)
				wptr_q <= (wptr_q == PTRW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (rd_en)
				rptr_q <= (rptr_q == PTRW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rd_item  = mem_q[rptr_q];
	assign rd_valid = (cnt_q != '0);
	assign level    = cnt_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ptqp_back.sv =====
// Back end: serializes two values per sample into an output byte register.
`default_nettype none
module ptqp_back import ptqp_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         rd_valid,
	input  wire item_t        rd_item,
	output logic              rd_en,
	input  wire logic         pop,
	output logic              empty,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_byte
);
	logic              busy_q, half_q, ov_q;
	logic [NB_W-1:0]   kcnt_q, nb_q;
	logic [VAL_W-1:0]  sh_q, q1_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              out_load, emit, last_k;

	assign out_load = !ov_q || pop;
	assign emit     = busy_q && out_load;
	assign last_k   = (kcnt_q == nb_q - 1'b1);
	assign rd_en    = rd_valid && (!busy_q || (emit && half_q && last_k));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			half_q <= 1'b0;
			kcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (out_load)
				ov_q <= emit;
			if (rd_en) begin
				busy_q <= 1'b1;
				half_q <= 1'b0;
				kcnt_q <= '0;
			end else if (emit) begin
				if (last_k) begin
					kcnt_q <= '0;
					if (half_q)
						busy_q <= 1'b0;
					else
						half_q <= 1'b1;
				end else begin
					kcnt_q <= kcnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= sh_q[BYTE_W-1:0];
			last_q <= half_q && last_k;
		end
		if (rd_en) begin
			sh_q <= rd_item.q0;
			q1_q <= rd_item.q1;
			nb_q <= rd_item.nbytes;
		end else if (emit) begin
			sh_q <= last_k ? q1_q : (sh_q >> BYTE_W);
		end
	end

	assign empty     = !ov_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;
endmodule
`default_nettype wire

// ===== hw/rtl/prob_triple_quantize_pack_core.sv =====
// Top level of the genotype probability quantize and byte pack block.
//
// Input is a queue-style write port: a sample (three probabilities with
// FRAC_BITS fraction bits, 2^FRAC_BITS = 1.0, plus a missing flag) is taken
// on a clock edge with push high and full low.
// Output is a queue-style read port: while empty is low, out_byte/last_byte
// show the oldest byte; it is consumed on an edge with pop high.
// Each sample gives 2*floor(B/8) bytes, first value then second value, each
// little-endian, with last_byte set on the final one; a missing sample gives
// the same count of zero bytes.
// bits_per_prob is written over cfg_valid/cfg_ready/cfg_data (ready is always
// high); values below 8 act as 8, above 32 as 32. Reset value is 16.
// A sample passes front stages s1 and s2, the queue and the shift register
// on its way to the single byte-wide output register, which sets throughput;
// the two-stage front end takes a word every cycle while full is low.
// A stalled pop holds the output byte; the front end keeps working until the
// queue plus the two front stages hold QUEUE_DEPTH samples, then full rises.
// Reset clears all valid flags and queue pointers; the block is empty.
`default_nettype none
`include "prob_triple_quantize_pack_core_assert.svh"
module prob_triple_quantize_pack_core import ptqp_pkg::*; #(
	parameter int FRAC_BITS   = 32,
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire logic [PROB_W-1:0] prob_hom_ref,
	input  wire logic [PROB_W-1:0] prob_het,
	input  wire logic [PROB_W-1:0] prob_hom_alt,
	input  wire logic              sample_missing,
	output logic                   empty,
	input  wire logic              pop,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   last_byte,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BITS_W-1:0] cfg_data
);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	logic [BITS_W-1:0] bits_q, bits_eff;
	logic              accept;
	logic              q_wr, q_rd, q_valid;
	item_t             q_wr_item, q_rd_item;
	logic [LW-1:0]     q_level;
	logic [1:0]        inflight;
	logic [LW:0]       credit_used;

	// config register; the user must write it only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= B_RESET;
		end else if (cfg_valid && cfg_ready) begin
			bits_q <= cfg_data;
		end
	end

	assign bits_eff = (bits_q < B_MIN) ? B_MIN : ((bits_q > B_MAX) ? B_MAX : bits_q);

	// credit: every sample in the front stages owns a queue slot
	assign credit_used = (LW + 1)'(q_level) + (LW + 1)'(inflight);
	assign full        = (credit_used >= (LW + 1)'(QUEUE_DEPTH));
	assign accept      = push && !full;

	ptqp_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.prob_hom_ref  (prob_hom_ref),
		.prob_het      (prob_het),
		.prob_hom_alt  (prob_hom_alt),
		.sample_missing(sample_missing),
		.bits_eff      (bits_eff),
		.wr_valid      (q_wr),
		.wr_item       (q_wr_item),
		.inflight      (inflight)
	);

	ptqp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_item (q_wr_item),
		.rd_en   (q_rd),
		.rd_item (q_rd_item),
		.rd_valid(q_valid),
		.level   (q_level)
	);

	ptqp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item),
		.rd_en    (q_rd),
		.pop      (pop),
		.empty    (empty),
		.out_byte (out_byte),
		.last_byte(last_byte)
	);

	// slots in use never exceed the queue size
	`PTQP_NEVER(a_credit_bound, clk, arst_n, credit_used > (LW + 1)'(QUEUE_DEPTH))
	// a front-end result always finds room in the queue
	`PTQP_ASSERT(a_wr_room, clk, arst_n, q_wr |-> (q_level < LW'(QUEUE_DEPTH)) || q_rd)
	// an accepted sample shows up in the front stages next cycle
	`PTQP_ASSERT(a_accept_tracked, clk, arst_n, accept |=> inflight != 2'd0)
endmodule
`default_nettype wire

// ===== dv/ptqp_tb_pkg.sv =====
// Packed-byte predictor and scoreboard for the quantize/pack testbench.
package ptqp_tb_pkg;
	import ptqp_pkg::*;

	localparam logic [PROB_W-1:0] ONE_FP = 33'h1_0000_0000;  // 1.0, 32 fraction bits

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              last;
	} packed_byte_t;

	class byte_pack_board;
		logic [BITS_W-1:0] width_reg;
		packed_byte_t      pending_bytes[$];
		int                samples;
		int                missing;
		int                bytes_seen;
		int                failures;

		function new();
			width_reg = B_RESET;
			samples = 0;
			missing = 0;
			bytes_seen = 0;
			failures = 0;
		endfunction

		// Largest-remainder quantization of one sample, then the byte stream it yields.
		function void note_sample(input logic [PROB_W-1:0] p_ref, p_het, p_alt,
				input logic miss);
			logic [PROB_W-1:0] prob[3];
			logic [63:0]       prod;
			logic [31:0]       whole[3];
			logic [31:0]       frac[3];
			logic [33:0]       frac_sum;
			logic [VAL_W:0]    qv[3];
			logic [VAL_W-1:0]  scale;
			int                bits, nbytes, rank, round_ups;
			packed_byte_t      pb;

			bits = (width_reg < B_MIN) ? int'(B_MIN) :
				(width_reg > B_MAX) ? int'(B_MAX) : int'(width_reg);
			nbytes = bits / 8;
			scale = VAL_W'((64'd1 << bits) - 64'd1);
			prob = '{p_ref, p_het, p_alt};
			frac_sum = '0;
			for (int i = 0; i < 3; i++) begin
				if (prob[i] > ONE_FP)
					prob[i] = ONE_FP;
				prod = 64'(prob[i]) * 64'(scale);
				whole[i] = prod[63:32];
				frac[i] = prod[31:0];
				frac_sum += 34'(frac[i]);
			end
			// round the remainder total to the nearest count, half up
			frac_sum += 34'h0_8000_0000;
			round_ups = int'(frac_sum[33:32]);
			for (int i = 0; i < 3; i++) begin
				rank = 0;
				for (int j = 0; j < 3; j++)
					if (frac[j] < frac[i] || (frac[j] == frac[i] && j < i))
						rank++;
				qv[i] = {1'b0, whole[i]};
				if (rank + round_ups >= 3 && frac[i] != 0)
					qv[i] += 1;
				if (qv[i] > {1'b0, scale})
					qv[i] = {1'b0, scale};
				if (miss)
					qv[i] = '0;
			end
			for (int v = 0; v < 2; v++)
				for (int k = 0; k < nbytes; k++) begin
					pb.value = qv[v][8*k +: 8];
					pb.last = (v == 1 && k == nbytes - 1);
					pending_bytes.push_back(pb);
				end
			samples++;
			if (miss)
				missing++;
		endfunction

		function void check_byte(input logic [BYTE_W-1:0] got, input logic got_last);
			packed_byte_t want;

			if (pending_bytes.size() == 0) begin
				$error("out_byte: no byte expected, got 0x%02h", got);
				failures++;
				return;
			end
			want = pending_bytes.pop_front();
			bytes_seen++;
			if (got !== want.value) begin
				$error("out_byte: expected 0x%02h, got 0x%02h", want.value, got);
				failures++;
			end
			if (got_last !== want.last) begin
				$error("last_byte: expected %0d, got %0d", want.last, got_last);
				failures++;
			end
		endfunction
	endclass
endpackage

// ===== dv/tb_prob_triple_quantize_pack_core.sv =====
// Testbench top for prob_triple_quantize_pack_core: directed and random samples, byte checks.
module tb_prob_triple_quantize_pack_core;
	timeunit 1ns;
	timeprecision 1ps;
	import ptqp_pkg::*;
	import ptqp_tb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [PROB_W-1:0] prob_hom_ref;
	logic [PROB_W-1:0] prob_het;
	logic [PROB_W-1:0] prob_hom_alt;
	logic              sample_missing;
	logic              empty;
	logic              pop;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [BITS_W-1:0] cfg_data;

	byte_pack_board board = new();
	bit             tx_quiet;        // sender runs back to back in this phase
	int             width_settings;

	prob_triple_quantize_pack_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.prob_hom_ref   (prob_hom_ref),
		.prob_het       (prob_het),
		.prob_hom_alt   (prob_hom_alt),
		.sample_missing (sample_missing),
		.empty          (empty),
		.pop            (pop),
		.out_byte       (out_byte),
		.last_byte      (last_byte),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: far above the slowest legal run (8 bytes per sample, every
	// byte stalled by the longest pop gap, plus the long hold-offs).
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// Monitor: everything is sampled at the rising edge, before the block's
	// own updates land, so a word counts exactly when its handshake fires.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				board.width_reg = cfg_data;
			if (push && !full)
				board.note_sample(prob_hom_ref, prob_het, prob_hom_alt, sample_missing);
			if (pop && !empty)
				board.check_byte(out_byte, last_byte);
		end
	end

	// Gap length: mostly none or short, now and then a long one.
	function automatic int idle_len(input bit quiet);
		int r;

		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PROB_W-1:0] corner_prob();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 33'd1;
			2: return 33'h0_FFFF_FFFF;
			3: return ONE_FP;
			default: return '1;
		endcase
	endfunction

	// Offer one sample word; push stays high into the next word unless a gap follows.
	task automatic send_sample(input logic [PROB_W-1:0] p_ref, p_het, p_alt,
			input logic miss);
		int gap;

		prob_hom_ref <= p_ref;
		prob_het <= p_het;
		prob_hom_alt <= p_alt;
		sample_missing <= miss;
		push <= 1'b1;
		do @(posedge clk); while (full);
		gap = idle_len(tx_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_width(input logic [BITS_W-1:0] b);
		cfg_data <= b;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		width_settings++;
	endtask

	// Stop offering and wait until every predicted byte has been popped.
	task automatic wait_drained();
		if (push)
			push <= 1'b0;
		do @(posedge clk); while (board.pending_bytes.size() != 0);
	endtask

	// Extremes, clamping above one, remainder ties and the missing flag.
	task automatic send_directed_set();
		send_sample('0, '0, '0, 1'b0);
		send_sample(ONE_FP, '0, '0, 1'b0);
		send_sample('0, ONE_FP, '0, 1'b0);
		send_sample('0, '0, ONE_FP, 1'b0);
		send_sample('1, '1, '1, 1'b0);                          // all above one
		send_sample(33'h1_0000_0001, '0, 33'h1_8000_0000, 1'b0);
		send_sample(33'h0_5555_5555, 33'h0_5555_5555, 33'h0_5555_5556, 1'b0);
		send_sample(33'h0_8000_0000, 33'h0_4000_0000, 33'h0_4000_0000, 1'b0); // tie, two up
		send_sample(33'h0_4000_0000, 33'h0_4000_0000, 33'h0_8000_0000, 1'b0);
		send_sample(33'h0_FFFF_FFFF, 33'd1, '0, 1'b0);
		send_sample(33'h0_AAAA_AAAA, 33'h0_5555_5555, 33'd1, 1'b0);
		send_sample('1, '1, '1, 1'b1);                          // missing, junk content
	endtask

	task automatic send_random_sample();
		logic [63:0]       a, b;
		logic [PROB_W-1:0] f[3];
		logic              miss;
		int                kind, rot;

		kind = $urandom_range(0, 99);
		rot = $urandom_range(0, 2);
		miss = ($urandom_range(0, 19) == 0);
		if (kind < 70) begin
			// proper distribution: three parts adding up to exactly one
			a = ($urandom_range(0, 15) == 0) ? 64'(ONE_FP) : 64'($urandom());
			b = {$urandom(), $urandom()} % (64'(ONE_FP) - a + 64'd1);
			f[0] = a[PROB_W-1:0];
			f[1] = b[PROB_W-1:0];
			f[2] = PROB_W'(64'(ONE_FP) - a - b);
		end else if (kind < 80) begin
			// two equal parts force equal remainders
			a = 64'($urandom_range(0, 32'h8000_0000));
			f[0] = a[PROB_W-1:0];
			f[1] = a[PROB_W-1:0];
			f[2] = PROB_W'(64'(ONE_FP) - 2 * a);
		end else if (kind < 92) begin
			for (int i = 0; i < 3; i++)
				f[i] = {1'($urandom_range(0, 1)), $urandom()};
			miss = 1'($urandom_range(0, 1));
		end else begin
			for (int i = 0; i < 3; i++)
				f[i] = corner_prob();
		end
		send_sample(f[rot], f[(rot + 1) % 3], f[(rot + 2) % 3], miss);
	endtask

	// Sender: directed words at the reset width and at 32 bits, then random
	// phases, each under its own width setting written while the block is idle.
	initial begin
		logic [BITS_W-1:0] widths[$];
		int                sent, phase_len;

		arst_n <= 1'b0;
		push <= 1'b0;
		prob_hom_ref <= '0;
		prob_het <= '0;
		prob_hom_alt <= '0;
		sample_missing <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		tx_quiet = 1'b0;
		width_settings = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed_set();
		wait_drained();
		write_width(B_MAX);
		send_directed_set();
		wait_drained();

		// below-range, above-range and non-multiple-of-eight widths come first
		widths = '{6'd8, 6'd0, 6'd63, 6'd24, 6'd12, 6'd7, 6'd33, 6'd16, 6'd31, 6'd32};
		sent = 0;
		while (sent < 390) begin
			if (widths.size() != 0)
				write_width(widths.pop_front());
			else
				write_width(BITS_W'($urandom_range(0, 63)));
			tx_quiet = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(15, 45);
			repeat (phase_len) send_random_sample();
			sent += phase_len;
			wait_drained();
		end
		repeat (12) @(posedge clk);

		$display("covered %0d samples (%0d missing) under %0d width writes, 0 to 63",
			board.samples, board.missing, width_settings);
		$display("%0d packed bytes compared, %0d mismatches", board.bytes_seen,
			board.failures);
		if (board.failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Receiver: pops with random gaps; every 500 bytes it holds off for a
	// long stretch so the queue fills and full pushes back on the sender.
	initial begin
		int gap, popped;
		bit quiet;

		pop <= 1'b0;
		popped = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			popped++;
			if (popped % 64 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (popped % 500 == 150) begin
				pop <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				gap = idle_len(quiet);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ptqp_pkg.sv
hw/rtl/ptqp_front.sv
hw/rtl/ptqp_queue.sv
hw/rtl/ptqp_back.sv
hw/rtl/prob_triple_quantize_pack_core.sv
dv/ptqp_tb_pkg.sv
dv/tb_prob_triple_quantize_pack_core.sv
